FILE: design/sst_pkg.sv
package sst_pkg;

    localparam int KW_MAX_LEN = 15;
    localparam int KW_COUNT   = 87;
    localparam int KW_LEN_W   = $clog2(KW_MAX_LEN + 1);
    localparam int KW_IDX_W   = $clog2(KW_MAX_LEN);

    typedef logic [6:0] t_kind;
    typedef logic [2:0] t_err;
    typedef logic [8*KW_MAX_LEN-1:0] t_kw_word;

    // Opcodes of the input beat
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Error codes
    localparam t_err E_NONE         = 3'd0;
    localparam t_err E_OPEN_COMMENT = 3'd1;
    localparam t_err E_HEX_EMPTY    = 3'd2;
    localparam t_err E_NUM_LETTER   = 3'd3;
    localparam t_err E_BAD_CHAR     = 3'd4;

    // Token kinds
    localparam t_kind K_RESERVED   = 7'd53;
    localparam t_kind K_INCR       = 7'd54;
    localparam t_kind K_ADD_ASSIGN = 7'd55;
    localparam t_kind K_ADD        = 7'd56;
    localparam t_kind K_DECR       = 7'd57;
    localparam t_kind K_SUB_ASSIGN = 7'd58;
    localparam t_kind K_SUB        = 7'd59;
    localparam t_kind K_MUL_ASSIGN = 7'd60;
    localparam t_kind K_MUL        = 7'd61;
    localparam t_kind K_DIV_ASSIGN = 7'd62;
    localparam t_kind K_DIV        = 7'd63;
    localparam t_kind K_MOD        = 7'd64;
    localparam t_kind K_LE         = 7'd65;
    localparam t_kind K_LT         = 7'd66;
    localparam t_kind K_GE         = 7'd67;
    localparam t_kind K_GT         = 7'd68;
    localparam t_kind K_EQ         = 7'd69;
    localparam t_kind K_ASSIGN     = 7'd70;
    localparam t_kind K_NE         = 7'd71;
    localparam t_kind K_NOT        = 7'd72;
    localparam t_kind K_LAND       = 7'd73;
    localparam t_kind K_AND        = 7'd74;
    localparam t_kind K_LOR        = 7'd75;
    localparam t_kind K_OR         = 7'd76;
    localparam t_kind K_LXOR       = 7'd77;
    localparam t_kind K_XOR        = 7'd78;
    localparam t_kind K_TILDE      = 7'd79;
    localparam t_kind K_LPAREN     = 7'd80;
    localparam t_kind K_RPAREN     = 7'd81;
    localparam t_kind K_LBRACK     = 7'd82;
    localparam t_kind K_RBRACK     = 7'd83;
    localparam t_kind K_LBRACE     = 7'd84;
    localparam t_kind K_RBRACE     = 7'd85;
    localparam t_kind K_SEMI       = 7'd86;
    localparam t_kind K_COMMA      = 7'd87;
    localparam t_kind K_DOT        = 7'd88;
    localparam t_kind K_COLON      = 7'd89;
    localparam t_kind K_QUEST      = 7'd90;
    localparam t_kind K_HASH       = 7'd91;
    localparam t_kind K_IDENT      = 7'd92;
    localparam t_kind K_INT        = 7'd93;
    localparam t_kind K_FLOAT      = 7'd94;
    localparam t_kind K_ERROR      = 7'd95;
    localparam t_kind K_EOF        = 7'd96;

    // Characters the scanner looks at by value
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SLASH = "/";
    localparam logic [7:0] CH_STAR  = "*";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_LX    = "x";
    localparam logic [7:0] CH_UX    = "X";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_LE    = "e";
    localparam logic [7:0] CH_UE    = "E";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_MINUS = "-";

    typedef enum logic [3:0] {
        M_IDLE,
        M_LINE,
        M_BLOCK,
        M_BLOCK_STAR,
        M_IDENT,
        M_HEX_PREFIX,
        M_HEX,
        M_DEC,
        M_EXP,
        M_DONE
    } t_mode;

    typedef struct packed {
        logic       opcode;
        logic [7:0] ch;
    } t_src_item;

    typedef struct packed {
        t_kind       kind;
        t_err        error_code;
        logic [31:0] start_offset;
        logic [15:0] token_length;
        logic [31:0] line_number;
        logic [31:0] column_number;
        logic        last;
    } t_tok_item;

    typedef struct packed {
        logic ws;
        logic dig;
        logic hex;
        logic idst;
    } t_cls;

    typedef struct packed {
        logic       is_end;
        logic [7:0] ch;
        t_cls       cls;
    } t_q_item;

    typedef struct packed {
        logic  hit;
        t_kind kind;
    } t_op_hit;

    localparam t_kw_word KW_WORD [KW_COUNT] = '{
        "attribute", "const", "uniform", "varying", "break", "continue", "do", "for",
        "while", "if", "else", "discard", "return", "struct", "void", "in", "out",
        "inout", "float", "int", "bool", "true", "false", "vec2", "vec3", "vec4",
        "ivec2", "ivec3", "ivec4", "bvec2", "bvec3", "bvec4", "mat2", "mat3", "mat4",
        "mat2x2", "mat3x3", "mat4x4", "mat2x3", "mat2x4", "mat3x2", "mat3x4",
        "mat4x2", "mat4x3", "sampler1D", "sampler2D", "sampler3D", "samplerCube",
        "sampler1DShadow", "sampler2DShadow", "invariant", "centroid", "precision",
        "lowp", "mediump", "highp",
        "asm", "class", "union", "enum", "typedef", "template", "this", "packed",
        "goto", "switch", "default", "inline", "noinline", "volatile", "public",
        "static", "extern", "external", "interface", "long", "short", "double",
        "half", "fixed", "unsigned", "input", "output", "sizeof", "cast",
        "namespace", "using"
    };

    localparam t_kind KW_KIND [KW_COUNT] = '{
        7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd8, 7'd9, 7'd10, 7'd11,
        7'd12, 7'd13, 7'd14, 7'd15, 7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21,
        7'd22, 7'd23, 7'd24, 7'd25, 7'd26, 7'd27, 7'd28, 7'd29, 7'd30, 7'd31,
        7'd32, 7'd33, 7'd34, 7'd32, 7'd33, 7'd34, 7'd35, 7'd36, 7'd37, 7'd38,
        7'd39, 7'd40, 7'd41, 7'd42, 7'd43, 7'd44, 7'd45, 7'd46, 7'd47, 7'd48,
        7'd49, 7'd50, 7'd51, 7'd52,
        K_RESERVED, K_RESERVED, K_RESERVED, K_RESERVED, K_RESERVED, K_RESERVED,
        K_RESERVED, K_RESERVED, K_RESERVED, K_RESERVED, K_RESERVED, K_RESERVED,
        K_RESERVED, K_RESERVED, K_RESERVED, K_RESERVED, K_RESERVED, K_RESERVED,
        K_RESERVED, K_RESERVED, K_RESERVED, K_RESERVED, K_RESERVED, K_RESERVED,
        K_RESERVED, K_RESERVED, K_RESERVED, K_RESERVED, K_RESERVED, K_RESERVED,
        K_RESERVED
    };

    // Length of a right-justified, zero-padded keyword
    function automatic logic [KW_LEN_W-1:0] kw_len(input t_kw_word w);
        int n;
        n = 0;
        for (int k = 0; k < KW_MAX_LEN; k++) begin
            if (w[8*k +: 8] != 8'h00) n = k + 1;
        end
        return KW_LEN_W'(n);
    endfunction

    // Left-justify so that character k sits at a fixed place
    function automatic t_kw_word kw_left(input t_kw_word w);
        return w << (8 * (KW_MAX_LEN - int'(kw_len(w))));
    endfunction

    function automatic t_cls classify(input logic [7:0] c);
        t_cls r;
        r.ws   = (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
        r.dig  = (c >= "0") && (c <= "9");
        r.hex  = r.dig || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
        r.idst = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
        return r;
    endfunction

    function automatic logic has_pair(input logic [7:0] c);
        return (c == "+") || (c == "-") || (c == "*") || (c == "/") || (c == "<") ||
               (c == ">") || (c == "=") || (c == "!") || (c == "&") || (c == "|") ||
               (c == "^");
    endfunction

    function automatic t_op_hit two_char(input logic [7:0] c0, input logic [7:0] c1);
        t_op_hit r;
        r = '{hit: 1'b0, kind: K_ERROR};
        case (c0)
            "+": begin
                if (c1 == "+") r = '{hit: 1'b1, kind: K_INCR};
                else if (c1 == "=") r = '{hit: 1'b1, kind: K_ADD_ASSIGN};
            end
            "-": begin
                if (c1 == "-") r = '{hit: 1'b1, kind: K_DECR};
                else if (c1 == "=") r = '{hit: 1'b1, kind: K_SUB_ASSIGN};
            end
            "*": if (c1 == "=") r = '{hit: 1'b1, kind: K_MUL_ASSIGN};
            "/": if (c1 == "=") r = '{hit: 1'b1, kind: K_DIV_ASSIGN};
            "<": if (c1 == "=") r = '{hit: 1'b1, kind: K_LE};
            ">": if (c1 == "=") r = '{hit: 1'b1, kind: K_GE};
            "=": if (c1 == "=") r = '{hit: 1'b1, kind: K_EQ};
            "!": if (c1 == "=") r = '{hit: 1'b1, kind: K_NE};
            "&": if (c1 == "&") r = '{hit: 1'b1, kind: K_LAND};
            "|": if (c1 == "|") r = '{hit: 1'b1, kind: K_LOR};
            "^": if (c1 == "^") r = '{hit: 1'b1, kind: K_LXOR};
            default: r = '{hit: 1'b0, kind: K_ERROR};
        endcase
        return r;
    endfunction

    function automatic t_op_hit one_char(input logic [7:0] c);
        t_op_hit r;
        r.hit = 1'b1;
        case (c)
            "+": r.kind = K_ADD;
            "-": r.kind = K_SUB;
            "*": r.kind = K_MUL;
            "/": r.kind = K_DIV;
            "%": r.kind = K_MOD;
            "<": r.kind = K_LT;
            ">": r.kind = K_GT;
            "=": r.kind = K_ASSIGN;
            "!": r.kind = K_NOT;
            "&": r.kind = K_AND;
            "|": r.kind = K_OR;
            "^": r.kind = K_XOR;
            "~": r.kind = K_TILDE;
            "(": r.kind = K_LPAREN;
            ")": r.kind = K_RPAREN;
            "[": r.kind = K_LBRACK;
            "]": r.kind = K_RBRACK;
            "{": r.kind = K_LBRACE;
            "}": r.kind = K_RBRACE;
            ";": r.kind = K_SEMI;
            ",": r.kind = K_COMMA;
            ".": r.kind = K_DOT;
            ":": r.kind = K_COLON;
            "?": r.kind = K_QUEST;
            "#": r.kind = K_HASH;
            default: begin
                r.hit  = 1'b0;
                r.kind = K_ERROR;
            end
        endcase
        return r;
    endfunction

endpackage

FILE: design/sst_fifo.sv
module sst_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

endmodule

FILE: design/sst_front.sv
module sst_front #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sst_pkg::t_src_item i_src,
    output logic               o_full,
    input  logic               i_q_pop,
    output sst_pkg::t_q_item   o_q_item,
    output logic               o_q_empty
);
    import sst_pkg::*;

    t_q_item cls_item;

    // Classify on the way in so the scanner sees ready-made class bits
    always_comb begin
        cls_item.is_end = (i_src.opcode == OP_END);
        cls_item.ch     = i_src.ch;
        cls_item.cls    = classify(i_src.ch);
    end

    sst_fifo #(
        .WIDTH ($bits(t_q_item)),
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cls_item),
        .o_full  (o_full),
        .i_pop   (i_q_pop),
        .o_data  (o_q_item),
        .o_empty (o_q_empty)
    );

endmodule

FILE: design/sst_kwmatch.sv
module sst_kwmatch (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_add,
    input  logic [7:0]          i_ch,
    output sst_pkg::t_kind      o_kind
);
    import sst_pkg::*;

    logic [KW_COUNT-1:0] r_cand, n_cand, hit, exact;
    logic [15:0]         r_len, idx;
    logic                in_range;
    logic [KW_IDX_W-1:0] idx_n;
    logic [KW_LEN_W-1:0] idx1;
    t_kind               r_kind, n_kind;

    assign idx      = i_start ? 16'd0 : r_len;
    assign in_range = (idx < 16'(KW_MAX_LEN));
    assign idx_n    = idx[KW_IDX_W-1:0];
    assign idx1     = KW_LEN_W'(idx_n) + KW_LEN_W'(1);

    for (genvar i = 0; i < KW_COUNT; i++) begin : g_kw
        localparam t_kw_word LJ = kw_left(KW_WORD[i]);
        localparam logic [KW_LEN_W-1:0] LEN = kw_len(KW_WORD[i]);
        assign hit[i]    = in_range && (LJ[8*(KW_MAX_LEN-1-int'(idx_n)) +: 8] == i_ch);
        assign n_cand[i] = (i_start || r_cand[i]) && hit[i];
        assign exact[i]  = n_cand[i] && (LEN == idx1);
    end

    // At most one entry matches exactly: the table holds no duplicates
    always_comb begin
        n_kind = '0;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (exact[i]) n_kind = n_kind | KW_KIND[i];
        end
        if (exact == '0) n_kind = K_IDENT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand <= '1;
            r_len  <= '0;
            r_kind <= K_IDENT;
        end else if (i_add) begin
            r_cand <= n_cand;
            r_len  <= (idx == 16'hFFFF) ? idx : idx + 16'd1;
            r_kind <= n_kind;
        end
    end

    assign o_kind = r_kind;

endmodule

FILE: design/sst_scan.sv
module sst_scan #(
    parameter int POSITION_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sst_pkg::t_q_item   i_q_item,
    input  logic               i_q_empty,
    output logic               o_q_pop,
    input  logic               i_out_full,
    output logic               o_out_push,
    output sst_pkg::t_tok_item o_out_tok
);
    import sst_pkg::*;

    localparam int PB = POSITION_BITS;

    typedef struct packed {
        logic [7:0] ch;
        t_cls       cls;
    } t_wbyte;

    t_mode   r_mode, n_mode, mode_sel;
    t_wbyte  r_win [3];
    t_wbyte  n_win [3];
    t_wbyte  sh_win [3];
    logic [1:0] r_cnt, cnt_after, take;
    logic    r_ended;
    logic [1:0] r_flags, n_flags;
    logic [PB-1:0] r_off, r_line, r_col, r_st_off, r_st_line, r_st_col;
    logic [PB-1:0] n_off, n_line, n_col, st_off, st_line, st_col;
    logic [PB:0]   off_sum, col_sum, line_sum;
    logic [PB-1:0] len_diff;

    logic go, c0v, c1v, c2v, eos0;
    logic [7:0] b0, b1;
    logic ws0, dig0, hex0, idst0, idc0, dig1, dig2;
    logic need1, wait1, is_cmt, is_hexp, is_num;
    logic dec_dig, dec_dot, dec_e, e_d, e_sign, e_sd, dec_wait, exp_go;
    t_op_hit two, one;

    logic  emit, last, mark, kw_start, kw_add, space, load, nl;
    t_kind kind, id_kind;
    t_err  code;

    // Window view
    assign c0v  = (r_cnt >= 2'd1);
    assign c1v  = (r_cnt >= 2'd2);
    assign c2v  = (r_cnt == 2'd3);
    assign b0   = r_win[0].ch;
    assign b1   = r_win[1].ch;
    assign eos0 = !c0v;
    assign ws0  = c0v && r_win[0].cls.ws;
    assign dig0 = c0v && r_win[0].cls.dig;
    assign hex0 = c0v && r_win[0].cls.hex;
    assign idst0 = c0v && r_win[0].cls.idst;
    assign idc0 = idst0 || dig0;
    assign dig1 = c1v && r_win[1].cls.dig;
    assign dig2 = c2v && r_win[2].cls.dig;

    // One move per cycle; hold while the result queue is full or the window awaits a byte
    assign go = !i_out_full && (r_mode != M_DONE) && (c0v || r_ended);

    // Idle-state decode
    assign need1   = dig0 || (c0v && (b0 == CH_DOT || has_pair(b0)));
    assign wait1   = need1 && !c1v && !r_ended;
    assign is_cmt  = c0v && (b0 == CH_SLASH) && c1v && (b1 == CH_SLASH || b1 == CH_STAR);
    assign is_hexp = c0v && (b0 == CH_ZERO) && c1v && (b1 == CH_LX || b1 == CH_UX);
    assign is_num  = dig0 || (c0v && (b0 == CH_DOT) && dig1);
    assign two     = two_char(b0, b1);
    assign one     = one_char(b0);

    // Decimal-state decode, including the exponent lookahead
    assign dec_dig  = dig0;
    assign dec_dot  = c0v && (b0 == CH_DOT) && !r_flags[1];
    assign dec_e    = c0v && (b0 == CH_LE || b0 == CH_UE);
    assign e_d      = dig1;
    assign e_sign   = c1v && (b1 == CH_PLUS || b1 == CH_MINUS);
    assign e_sd     = e_sign && dig2;
    assign exp_go   = dec_e && (e_d || e_sd);
    assign dec_wait = dec_e && ((!c1v && !r_ended) || (e_sign && !c2v && !r_ended));

    // Next state
    always_comb begin
        mode_sel = r_mode;
        unique case (r_mode)
            M_IDLE: begin
                if (eos0)           mode_sel = M_DONE;
                else if (ws0)       mode_sel = M_IDLE;
                else if (idst0)     mode_sel = M_IDENT;
                else if (wait1)     mode_sel = M_IDLE;
                else if (is_cmt)    mode_sel = (b1 == CH_SLASH) ? M_LINE : M_BLOCK;
                else if (is_hexp)   mode_sel = M_HEX_PREFIX;
                else if (is_num)    mode_sel = M_DEC;
                else                mode_sel = M_IDLE;
            end
            M_LINE: begin
                if (eos0 || b0 == CH_NL) mode_sel = M_IDLE;
            end
            M_BLOCK, M_BLOCK_STAR: begin
                if (eos0) mode_sel = M_DONE;
                else if (r_mode == M_BLOCK_STAR && b0 == CH_SLASH) mode_sel = M_IDLE;
                else mode_sel = (b0 == CH_STAR) ? M_BLOCK_STAR : M_BLOCK;
            end
            M_IDENT:      if (!idc0) mode_sel = M_IDLE;
            M_HEX_PREFIX: mode_sel = hex0 ? M_HEX : M_IDLE;
            M_HEX:        if (!hex0) mode_sel = M_IDLE;
            M_DEC: begin
                if (dec_dig || dec_dot || dec_wait) mode_sel = M_DEC;
                else if (exp_go) mode_sel = M_EXP;
                else mode_sel = M_IDLE;
            end
            M_EXP:  if (!dig0) mode_sel = M_IDLE;
            M_DONE: mode_sel = M_DONE;
            default: mode_sel = M_DONE;
        endcase
        n_mode = go ? mode_sel : r_mode;
    end

    // Move outputs: bytes taken, token emitted, marks and flags
    always_comb begin
        take     = 2'd0;
        emit     = 1'b0;
        kind     = K_ERROR;
        code     = E_NONE;
        last     = 1'b0;
        mark     = 1'b0;
        kw_start = 1'b0;
        kw_add   = 1'b0;
        n_flags  = r_flags;
        unique case (r_mode)
            M_IDLE: begin
                if (eos0) begin
                    mark = 1'b1;
                    emit = 1'b1;
                    kind = K_EOF;
                    last = 1'b1;
                end else if (ws0) begin
                    take = 2'd1;
                end else if (idst0) begin
                    mark     = 1'b1;
                    kw_start = 1'b1;
                    kw_add   = 1'b1;
                    take     = 2'd1;
                end else if (wait1) begin
                    take = 2'd0;
                end else if (is_cmt) begin
                    take = 2'd2;
                end else begin
                    mark = 1'b1;
                    if (is_hexp) begin
                        take = 2'd2;
                    end else if (is_num) begin
                        n_flags = (b0 == CH_DOT) ? 2'b11 : 2'b00;
                        take    = 2'd1;
                    end else if (c1v && two.hit) begin
                        take = 2'd2;
                        emit = 1'b1;
                        kind = two.kind;
                    end else begin
                        take = 2'd1;
                        emit = 1'b1;
                        kind = one.hit ? one.kind : K_ERROR;
                        code = one.hit ? E_NONE : E_BAD_CHAR;
                    end
                end
            end
            M_LINE: begin
                if (!(eos0 || b0 == CH_NL)) take = 2'd1;
            end
            M_BLOCK, M_BLOCK_STAR: begin
                if (eos0) begin
                    mark = 1'b1;
                    emit = 1'b1;
                    kind = K_ERROR;
                    code = E_OPEN_COMMENT;
                    last = 1'b1;
                end else begin
                    take = 2'd1;
                end
            end
            M_IDENT: begin
                if (idc0) begin
                    kw_add = 1'b1;
                    take   = 2'd1;
                end else begin
                    emit = 1'b1;
                    kind = id_kind;
                end
            end
            M_HEX_PREFIX: begin
                if (hex0) begin
                    take = 2'd1;
                end else begin
                    emit = 1'b1;
                    kind = K_ERROR;
                    code = E_HEX_EMPTY;
                end
            end
            M_HEX: begin
                if (hex0) begin
                    take = 2'd1;
                end else begin
                    emit = 1'b1;
                    kind = K_INT;
                end
            end
            M_DEC, M_EXP: begin
                if (dig0) begin
                    take = 2'd1;
                end else if (r_mode == M_DEC && dec_dot) begin
                    n_flags = 2'b11;
                    take    = 2'd1;
                end else if (r_mode == M_DEC && dec_wait) begin
                    take = 2'd0;
                end else if (r_mode == M_DEC && exp_go) begin
                    n_flags = r_flags | 2'b01;
                    take    = e_d ? 2'd1 : 2'd2;
                end else begin
                    emit = 1'b1;
                    kind = idst0 ? K_ERROR : (r_flags[0] ? K_FLOAT : K_INT);
                    code = idst0 ? E_NUM_LETTER : E_NONE;
                end
            end
            M_DONE: take = 2'd0;
            default: take = 2'd0;
        endcase
    end

    sst_kwmatch u_kw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (go && kw_start),
        .i_add   (go && kw_add),
        .i_ch    (b0),
        .o_kind  (id_kind)
    );

    // Position after the bytes taken this move
    assign nl       = (take != 2'd0) && (b0 == CH_NL);
    assign off_sum  = {1'b0, r_off} + (PB+1)'(take);
    assign col_sum  = {1'b0, r_col} + (PB+1)'(take);
    assign line_sum = {1'b0, r_line} + (PB+1)'(1);
    assign n_off    = off_sum[PB] ? '1 : off_sum[PB-1:0];
    assign n_line   = !nl ? r_line : (line_sum[PB] ? '1 : line_sum[PB-1:0]);
    assign n_col    = nl ? PB'(1) : (col_sum[PB] ? '1 : col_sum[PB-1:0]);

    assign st_off   = mark ? r_off  : r_st_off;
    assign st_line  = mark ? r_line : r_st_line;
    assign st_col   = mark ? r_col  : r_st_col;
    assign len_diff = n_off - st_off;

    always_comb begin
        o_out_tok.kind       = kind;
        o_out_tok.error_code = code;
        o_out_tok.last       = last;
    end

    if (PB > 32) begin : g_wide
        assign o_out_tok.start_offset  = (|st_off[PB-1:32])  ? '1 : st_off[31:0];
        assign o_out_tok.line_number   = (|st_line[PB-1:32]) ? '1 : st_line[31:0];
        assign o_out_tok.column_number = (|st_col[PB-1:32])  ? '1 : st_col[31:0];
    end else begin : g_narrow
        assign o_out_tok.start_offset  = 32'(st_off);
        assign o_out_tok.line_number   = 32'(st_line);
        assign o_out_tok.column_number = 32'(st_col);
    end

    if (PB > 16) begin : g_len_wide
        assign o_out_tok.token_length = (|len_diff[PB-1:16]) ? 16'hFFFF : len_diff[15:0];
    end else begin : g_len_narrow
        assign o_out_tok.token_length = 16'(len_diff);
    end

    assign o_out_push = go && emit;

    // Window refill from the front queue; everything after the end beat is dropped
    assign cnt_after = r_cnt - (go ? take : 2'd0);
    assign space     = (cnt_after != 2'd3);
    assign load      = !i_q_empty && !r_ended && space;
    assign o_q_pop   = !i_q_empty && (r_ended || space);

    always_comb begin
        case (go ? take : 2'd0)
            2'd1:    sh_win = '{r_win[1], r_win[2], r_win[2]};
            2'd2:    sh_win = '{r_win[2], r_win[2], r_win[2]};
            default: sh_win = r_win;
        endcase
        n_win = sh_win;
        if (load && !i_q_item.is_end) begin
            n_win[cnt_after] = '{ch: i_q_item.ch, cls: i_q_item.cls};
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        if (go && mark) begin
            r_st_off  <= r_off;
            r_st_line <= r_line;
            r_st_col  <= r_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_cnt   <= 2'd0;
            r_ended <= 1'b0;
            r_flags <= 2'b00;
            r_off   <= '0;
            r_line  <= PB'(1);
            r_col   <= PB'(1);
        end else begin
            r_mode  <= n_mode;
            r_cnt   <= cnt_after + 2'(load && !i_q_item.is_end);
            if (load && i_q_item.is_end) r_ended <= 1'b1;
            if (go) begin
                r_flags <= n_flags;
                r_off   <= n_off;
                r_line  <= n_line;
                r_col   <= n_col;
            end
        end
    end

endmodule

FILE: design/shader_source_tokenizer.sv
// A beat is written into the input queue and then loaded into the scanner window; a token
// decided by that beat is written into the result queue and shows on o_tok from there.
// Throughput: one scanner move per cycle while the result queue has room, at most one byte
// refilled per cycle; a lexeme that ends only on the next byte (identifier, number, hex) costs one
// move that takes no byte, so dense text runs below one byte per cycle and full stalls the source
// while the queue catches up. Reset: synchronous, active low; clears both queues, the scan state,
// positions (line and column to one) and the end-of-source flag. No clearing pass is needed.
module shader_source_tokenizer #(
    parameter int POSITION_BITS   = 32,
    parameter int IN_QUEUE_DEPTH  = 4,
    parameter int OUT_QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // source side: push/full
    input  logic               push,
    output logic               full,
    input  sst_pkg::t_src_item i_src,
    // token side: empty/pop
    output logic               empty,
    input  logic               pop,
    output sst_pkg::t_tok_item o_tok
);
    import sst_pkg::*;

    t_q_item   q_item;
    logic      q_empty, q_pop;
    logic      tok_push, tok_full;
    t_tok_item tok;

    // Front: classify each source beat and hold it in a short queue so the
    // producer keeps streaming while the scanner waits on lookahead or on
    // the token consumer.
    sst_front #(
        .DEPTH (IN_QUEUE_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_src     (i_src),
        .o_full    (full),
        .i_q_pop   (q_pop),
        .o_q_item  (q_item),
        .o_q_empty (q_empty)
    );

    // Back: three-byte lookahead window plus the scan state machine. One move per cycle,
    // held while the result queue is full: drop trivia, advance a lexeme, or emit one token.
    sst_scan #(
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_item   (q_item),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .i_out_full (tok_full),
        .o_out_push (tok_push),
        .o_out_tok  (tok)
    );

    // Result queue: finished tokens wait here, so the scanner keeps moving
    // while the consumer holds off pop.
    sst_fifo #(
        .WIDTH ($bits(t_tok_item)),
        .DEPTH (OUT_QUEUE_DEPTH)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (tok_push),
        .i_data  (tok),
        .o_full  (tok_full),
        .i_pop   (pop),
        .o_data  (o_tok),
        .o_empty (empty)
    );

    // The scanner never pushes into a full result queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_push |-> !tok_full)
        else $error("token pushed into full result queue");

    // Only end-of-source or an open comment closes the stream
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tok_push && tok.last) |->
            (tok.kind == K_EOF || (tok.kind == K_ERROR && tok.error_code == E_OPEN_COMMENT)))
        else $error("last flag on a non-final token");

    // Error code is set exactly on error tokens
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_push |-> ((tok.kind == K_ERROR) == (tok.error_code != E_NONE)))
        else $error("error code does not match token kind");

    // Nothing is emitted after the final token
    a_quiet_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tok_push && tok.last) |=> !tok_push)
        else $error("token emitted after the final token");

endmodule
